[rtl/fsmm_pkg.sv]
// Package for the frame slot mailbox manager: command codes, slot states,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsmm_pkg;

	localparam int DATA_W = 32;
	localparam int IN_TDATA_W = 136;
	localparam int OUT_TDATA_W = 144;
	localparam int CMD_W = 3;

	typedef enum logic [2:0] {
		CMD_CLAIM    = 3'd0,
		CMD_CANCEL   = 3'd1,
		CMD_PUBLISH  = 3'd2,
		CMD_ACQUIRE  = 3'd3,
		CMD_RETIRE   = 3'd4,
		CMD_FENCE    = 3'd5,
		CMD_FLUSH    = 3'd6,
		CMD_QUERY    = 3'd7
	} cmd_code_t;

	typedef enum logic [2:0] {
		SS_FREE       = 3'd0,
		SS_PRODUCING  = 3'd1,
		SS_READY      = 3'd2,
		SS_DISPLAYING = 3'd3,
		SS_RETIRING   = 3'd4
	} slot_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SCAN,
		CS_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic scan_clear;
		logic scan_step;
		logic exec;
	} fsmm_cmd_t;

	typedef struct packed {
		logic scan_last;
	} fsmm_status_t;

endpackage

`default_nettype wire

[rtl/fsmm_ctrl.sv]
// Controller for the frame slot mailbox manager: sequences accept, slot scan
// and execute, and owns the output valid flag. Depends on fsmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmm_ctrl import fsmm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [CMD_W-1:0] in_command,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire fsmm_status_t     status,
	output fsmm_cmd_t             cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_room;

	assign out_room  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in    = 1'b1;
					cmd.scan_clear = 1'b1;
					// acquire needs the newest ready slot before it can execute
					state_d = (cmd_code_t'(in_command) == CMD_ACQUIRE) ? CS_SCAN : CS_EXEC;
				end
			end
			CS_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (out_room) begin
					cmd.exec = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/fsmm_dpath.sv]
// Datapath for the frame slot mailbox manager: input registers, slot table,
// generation and starvation registers, acquire scan and output register.
// Depends on fsmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsmm_dpath import fsmm_pkg::*; #(
	parameter int SLOT_COUNT = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire fsmm_cmd_t              cmd,
	output fsmm_status_t                status,
	input  wire logic [IN_TDATA_W-1:0]  in_tdata,
	input  wire logic [CMD_W-1:0]       in_tuser,
	input  wire logic                   cfg_we,
	input  wire logic [DATA_W-1:0]      cfg_wdata,
	output logic [OUT_TDATA_W-1:0]      out_tdata
);

	localparam int IW = $clog2(SLOT_COUNT);

	// input item
	cmd_code_t         in_cmd_q;
	logic [7:0]        in_slot_q;
	logic [DATA_W-1:0] in_tgen_q, in_tseq_q, in_rgen_q, in_fval_q;

	// slot table
	slot_state_t       sl_state_q [SLOT_COUNT];
	logic [DATA_W-1:0] sl_claim_q [SLOT_COUNT];
	logic [DATA_W-1:0] sl_tgen_q  [SLOT_COUNT];
	logic [DATA_W-1:0] sl_tseq_q  [SLOT_COUNT];
	logic [DATA_W-1:0] sl_fence_q [SLOT_COUNT];
	slot_state_t       sl_state_d [SLOT_COUNT];
	logic [DATA_W-1:0] sl_claim_d [SLOT_COUNT];
	logic [DATA_W-1:0] sl_tgen_d  [SLOT_COUNT];
	logic [DATA_W-1:0] sl_tseq_d  [SLOT_COUNT];
	logic [DATA_W-1:0] sl_fence_d [SLOT_COUNT];

	logic [DATA_W-1:0] cur_gen_q, cur_gen_d;
	logic [DATA_W-1:0] last_seq_q, last_seq_d;
	logic [DATA_W-1:0] starv_q, starv_d;

	// acquire scan
	logic [IW-1:0]     scan_q;
	logic              found_q;
	logic [IW-1:0]     best_q;
	logic [DATA_W-1:0] best_seq_q;

	logic              in_range;
	logic [IW-1:0]     s_idx;
	logic [IW-1:0]     rd_idx;
	slot_state_t       rd_state;
	logic [DATA_W-1:0] rd_claim, rd_tgen, rd_tseq;

	logic              ok, rvalid, free_found;
	logic [3:0]        chosen, rslot;
	logic [DATA_W-1:0] cgen, cseq;
	slot_state_t       qstate;
	logic [IW-1:0]     free_idx;
	logic [OUT_TDATA_W-1:0] out_tdata_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_cmd_q  <= cmd_code_t'(in_tuser);
			in_slot_q <= in_tdata[7:0];
			in_tgen_q <= in_tdata[39:8];
			in_tseq_q <= in_tdata[71:40];
			in_rgen_q <= in_tdata[103:72];
			in_fval_q <= in_tdata[135:104];
		end
	end

	assign in_range = in_slot_q < 8'(SLOT_COUNT);
	assign s_idx    = in_range ? in_slot_q[IW-1:0] : '0;
	assign rd_idx   = cmd.scan_step ? scan_q : s_idx;
	assign rd_state = sl_state_q[rd_idx];
	assign rd_claim = sl_claim_q[rd_idx];
	assign rd_tgen  = sl_tgen_q[rd_idx];
	assign rd_tseq  = sl_tseq_q[rd_idx];

	assign status.scan_last = (scan_q == IW'(SLOT_COUNT - 1));

	// walk the slots one a cycle, keep the lowest index with the highest sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (rd_state == SS_READY && rd_tgen == in_rgen_q &&
			    (!found_q || rd_tseq > best_seq_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && rd_state == SS_READY && rd_tgen == in_rgen_q &&
		    (!found_q || rd_tseq > best_seq_q)) begin
			best_q     <= scan_q;
			best_seq_q <= rd_tseq;
		end
	end

	always_comb begin
		sl_state_d = sl_state_q;
		sl_claim_d = sl_claim_q;
		sl_tgen_d  = sl_tgen_q;
		sl_tseq_d  = sl_tseq_q;
		sl_fence_d = sl_fence_q;
		cur_gen_d  = cur_gen_q;
		last_seq_d = last_seq_q;
		starv_d    = starv_q;
		ok         = 1'b0;
		chosen     = '0;
		cgen       = '0;
		cseq       = '0;
		rvalid     = 1'b0;
		rslot      = '0;
		qstate     = SS_FREE;
		free_found = 1'b0;
		free_idx   = '0;
		unique case (in_cmd_q)
			CMD_CLAIM: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (!free_found && sl_state_q[i] == SS_FREE) begin
						free_found = 1'b1;
						free_idx   = IW'(i);
					end
				end
				if (free_found) begin
					sl_state_d[free_idx] = SS_PRODUCING;
					sl_claim_d[free_idx] = cur_gen_q;
					ok     = 1'b1;
					chosen = 4'(free_idx);
				end else if (starv_q != '1) begin
					starv_d = starv_q + 1'b1;
				end
			end
			CMD_CANCEL: begin
				if (in_range && rd_state == SS_PRODUCING) begin
					sl_state_d[s_idx] = SS_FREE;
					sl_claim_d[s_idx] = '0;
					sl_tgen_d[s_idx]  = '0;
					sl_tseq_d[s_idx]  = '0;
					sl_fence_d[s_idx] = '0;
					ok = 1'b1;
				end
			end
			CMD_PUBLISH: begin
				if (in_range && rd_state == SS_PRODUCING) begin
					if (rd_claim != cur_gen_q || in_tgen_q != cur_gen_q ||
					    in_tseq_q == '0 || in_tseq_q <= last_seq_q) begin
						// bad token: drop the claim
						sl_state_d[s_idx] = SS_FREE;
						sl_claim_d[s_idx] = '0;
						sl_tgen_d[s_idx]  = '0;
						sl_tseq_d[s_idx]  = '0;
						sl_fence_d[s_idx] = '0;
					end else begin
						sl_state_d[s_idx] = SS_READY;
						sl_tgen_d[s_idx]  = in_tgen_q;
						sl_tseq_d[s_idx]  = in_tseq_q;
						last_seq_d = in_tseq_q;
						ok = 1'b1;
					end
				end
			end
			CMD_ACQUIRE: begin
				if (in_rgen_q == cur_gen_q && found_q) begin
					ok     = 1'b1;
					chosen = 4'(best_q);
					// the chosen slot matched the request generation
					cgen   = in_rgen_q;
					cseq   = best_seq_q;
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (sl_state_q[i] == SS_DISPLAYING) begin
							sl_state_d[i] = SS_RETIRING;
							sl_fence_d[i] = '0;
							rvalid = 1'b1;
							rslot  = 4'(i);
						end else if (sl_state_q[i] == SS_READY && IW'(i) != best_q) begin
							sl_state_d[i] = SS_FREE;
							sl_claim_d[i] = '0;
							sl_tgen_d[i]  = '0;
							sl_tseq_d[i]  = '0;
							sl_fence_d[i] = '0;
						end
					end
					sl_state_d[best_q] = SS_DISPLAYING;
				end
			end
			CMD_RETIRE: begin
				if (in_range && rd_state == SS_RETIRING && in_fval_q != '0) begin
					sl_fence_d[s_idx] = in_fval_q;
					ok = 1'b1;
				end
			end
			CMD_FENCE: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (sl_state_q[i] == SS_RETIRING && sl_fence_q[i] != '0 &&
					    sl_fence_q[i] <= in_fval_q) begin
						sl_state_d[i] = SS_FREE;
						sl_claim_d[i] = '0;
						sl_tgen_d[i]  = '0;
						sl_tseq_d[i]  = '0;
						sl_fence_d[i] = '0;
					end
				end
				ok = 1'b1;
			end
			CMD_FLUSH: begin
				cur_gen_d  = in_rgen_q;
				last_seq_d = '0;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (sl_state_q[i] == SS_READY) begin
						sl_state_d[i] = SS_FREE;
						sl_claim_d[i] = '0;
						sl_tgen_d[i]  = '0;
						sl_tseq_d[i]  = '0;
						sl_fence_d[i] = '0;
					end
				end
				ok = 1'b1;
			end
			CMD_QUERY: begin
				if (in_range) begin
					qstate = rd_state;
					ok     = 1'b1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				sl_state_q[i] <= SS_FREE;
				sl_claim_q[i] <= '0;
				sl_tgen_q[i]  <= '0;
				sl_tseq_q[i]  <= '0;
				sl_fence_q[i] <= '0;
			end
			cur_gen_q  <= '0;
			last_seq_q <= '0;
			starv_q    <= '0;
		end else if (cmd.exec) begin
			sl_state_q <= sl_state_d;
			sl_claim_q <= sl_claim_d;
			sl_tgen_q  <= sl_tgen_d;
			sl_tseq_q  <= sl_tseq_d;
			sl_fence_q <= sl_fence_d;
			cur_gen_q  <= cur_gen_d;
			last_seq_q <= last_seq_d;
			starv_q    <= starv_d;
		end else if (cfg_we) begin
			// start-of-stream load of the generation
			cur_gen_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_tdata_q <= {3'b000, starv_d, cur_gen_d, qstate, rslot, rvalid,
			                cseq, cgen, chosen, ok};
		end
	end

	assign out_tdata = out_tdata_q;

endmodule

`default_nettype wire

[rtl/frame_slot_mailbox_manager.sv]
// Top level of the frame slot mailbox manager: joins controller and datapath.
// Depends on fsmm_pkg, fsmm_ctrl and fsmm_dpath.
//
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata 136 b, tuser = command
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata 144 b, one result per item
//  cfg      | in        | cfg_we                      | cfg_wdata = start generation
//
// Each item is registered, then executed; acquire adds a scan between the two
// that walks the slots one a cycle, looking for the newest ready frame.
// A new item is taken while the previous result waits in the output register;
// execution holds until that register is free.
// Reset frees all slots and clears generation, sequence and starvation count.
`timescale 1ns / 1ps
`default_nettype none

module frame_slot_mailbox_manager import fsmm_pkg::*; #(
	parameter int SLOT_COUNT = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// slot_index[7:0], token_generation[39:8], token_sequence[71:40],
	// request_generation[103:72], fence_value[135:104]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// command[2:0]
	input  wire logic [CMD_W-1:0]       s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// success[0], chosen_slot[4:1], chosen_generation[36:5], chosen_sequence[68:37],
	// retiring_valid[69], retiring_slot[73:70], queried_state[76:74],
	// current_generation_out[108:77], starvation_count_out[140:109], zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [DATA_W-1:0]      cfg_wdata
);

	fsmm_cmd_t    cmd;
	fsmm_status_t status;

	fsmm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	fsmm_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_tdata (m_axis_tdata)
	);

	// a result never overwrites one that has not been taken
	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten before it was taken");

	// executing an item always presents a result next cycle
	a_exec_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_axis_tvalid)
		else $error("executed item produced no result");

	// one item at a time: no new item right after one is accepted
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second item accepted while one is in flight");

endmodule

`default_nettype wire
